@@ design/mrr_pkg.sv @@
// Shared types, constants and CRC helper for the Modbus RTU response receiver.
`default_nettype none

package mrr_pkg;

  localparam int StoreDepth = 69;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int LenW       = 7;

  localparam logic [LenW-1:0] MinLen = 7'd5;
  localparam logic [LenW-1:0] MaxLen = 7'd69;
  localparam logic [LenW-1:0] RstLen = 7'd8;

  localparam int MaxRegs   = 32;
  localparam int ResultCap = 32;
  localparam int CntCap    = (MaxRegs < ResultCap) ? MaxRegs : ResultCap;

  localparam logic [7:0]  FcRead  = 8'h03;
  localparam logic [7:0]  FcWrite = 8'h06;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // APB register map (word index)
  localparam logic RegExpectedLength = 1'b0;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StCrcErr    = 2'd1,
    StUnknownFc = 2'd2,
    StNoValues  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_RD_HI,
    S_RD_LO,
    S_RD_WAIT,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    TagNone,
    TagScan,
    TagHi,
    TagLo
  } rd_tag_e;

  typedef struct packed {
    logic take_in;   // request on the input channel this cycle
    logic scan_rd;   // read next frame byte for CRC/header scan
    logic rd_hi;     // read high byte of current register value
    logic rd_lo;     // read low byte of current register value
    logic load_out;  // load result into the output register
    logic next_val;  // advance value index
    logic finish;    // frame done: clear byte count and CRC
  } dp_cmd_t;

  typedef struct packed {
    logic frame_done;  // accepted byte completes the frame
    logic scan_last;   // scan read of the final frame byte
    logic multi;       // good read reply with at least one value
    logic last_val;    // current value is the final one
    logic out_free;    // output register can take a result
  } dp_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/mrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mrr_ram #(
  parameter int Width = 8,
  parameter int Depth = 69
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/mrr_ctrl.sv @@
// Sequencer for byte intake, frame scan and result emission.
`default_nettype none

module mrr_ctrl
  import mrr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire dp_stat_t stat_i,
  output      dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.frame_done) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: state_d = S_DECIDE;
      S_DECIDE:   state_d = stat_i.multi ? S_RD_HI : S_EMIT;
      S_RD_HI:    state_d = S_RD_LO;
      S_RD_LO:    state_d = S_RD_WAIT;
      S_RD_WAIT:  state_d = S_EMIT;
      S_EMIT: begin
        if (stat_i.out_free) begin
          state_d = (!stat_i.multi || stat_i.last_val) ? S_IDLE : S_RD_HI;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      S_SCAN:  cmd_o.scan_rd = 1'b1;
      S_RD_HI: cmd_o.rd_hi   = 1'b1;
      S_RD_LO: cmd_o.rd_lo   = 1'b1;
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (!stat_i.multi || stat_i.last_val) begin
            cmd_o.finish = 1'b1;
          end else begin
            cmd_o.next_val = 1'b1;
          end
        end
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/mrr_datapath.sv @@
// Byte counter, CRC accumulator, header capture and output register.
`default_nettype none

module mrr_datapath
  import mrr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  output      dp_stat_t         stat_o,
  input  wire logic [LenW-1:0]  expected_length_i,
  input  wire logic             in_action_i,
  input  wire logic [7:0]       in_byte_i,
  // frame store port
  output      logic             ram_we_o,
  output      logic [AddrW-1:0] ram_waddr_o,
  output      logic [7:0]       ram_wdata_o,
  output      logic             ram_re_o,
  output      logic [AddrW-1:0] ram_raddr_o,
  input  wire logic [7:0]       ram_rdata_i,
  // result register
  input  wire logic             out_ready_i,
  output      logic             out_valid_o,
  output      logic [47:0]      out_data_o,
  output      logic             out_kind_o,
  output      logic             out_last_o
);

  logic [LenW-1:0]  held_q, held_d;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] scan_q;
  logic [AddrW-1:0] rd_idx_q;
  rd_tag_e          tag_q, tag_d;
  logic [15:0]      crc_q;
  logic [4:0]       vi_q;
  logic             out_valid_q;
  logic [47:0]      out_data_q;
  logic             out_kind_q;
  logic             out_last_q;

  logic [7:0] addr_q, fc_q, b2_q, b3_q, b4_q, b5_q, crc_lo_q, crc_hi_q;
  logic [7:0] val_hi_q, val_lo_q;

  // effective length, saturated to the legal frame range
  logic [LenW-1:0] len_eff;
  always_comb begin
    if (expected_length_i < MinLen) begin
      len_eff = MinLen;
    end else if (expected_length_i > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = expected_length_i;
    end
  end

  logic            held_full;
  logic [LenW-1:0] held_inc;
  assign held_full = (held_q >= LenW'(StoreDepth));
  assign held_inc  = held_full ? held_q : held_q + LenW'(1);

  assign ram_we_o    = cmd_i.take_in && !in_action_i && !held_full;
  assign ram_waddr_o = AddrW'(held_q);
  assign ram_wdata_o = in_byte_i;

  // read address: scan walk, or value bytes at 3+2i / 4+2i
  logic [AddrW-1:0] val_base;
  assign val_base = AddrW'({vi_q, 1'b0});
  always_comb begin
    ram_re_o    = cmd_i.scan_rd || cmd_i.rd_hi || cmd_i.rd_lo;
    ram_raddr_o = scan_q;
    tag_d       = TagNone;
    if (cmd_i.scan_rd) begin
      tag_d = TagScan;
    end else if (cmd_i.rd_hi) begin
      ram_raddr_o = val_base + AddrW'(3);
      tag_d       = TagHi;
    end else if (cmd_i.rd_lo) begin
      ram_raddr_o = val_base + AddrW'(4);
      tag_d       = TagLo;
    end
  end

  always_comb begin
    held_d = held_q;
    if (cmd_i.finish) begin
      held_d = '0;
    end else if (cmd_i.take_in) begin
      held_d = in_action_i ? '0 : held_inc;
    end
  end

  logic [LenW-1:0] len_m1, len_m2;
  assign len_m1 = len_q - LenW'(1);
  assign len_m2 = len_q - LenW'(2);

  logic scan_crc;
  assign scan_crc = (tag_q == TagScan) && (LenW'(rd_idx_q) < len_m2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      scan_q      <= '0;
      tag_q       <= TagNone;
      crc_q       <= CrcInit;
      vi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      tag_q  <= tag_d;
      if (cmd_i.take_in) begin
        scan_q <= '0;
        vi_q   <= '0;
      end else begin
        if (cmd_i.scan_rd)  scan_q <= scan_q + AddrW'(1);
        if (cmd_i.next_val) vi_q   <= vi_q + 5'd1;
      end
      if (cmd_i.finish) begin
        crc_q <= CrcInit;
      end else if (scan_crc) begin
        crc_q <= crc_byte(crc_q, ram_rdata_i);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) len_q <= len_eff;
    if (cmd_i.scan_rd) rd_idx_q <= scan_q;
    if (tag_q == TagScan) begin
      if (rd_idx_q == AddrW'(0)) addr_q <= ram_rdata_i;
      if (rd_idx_q == AddrW'(1)) fc_q   <= ram_rdata_i;
      if (rd_idx_q == AddrW'(2)) b2_q   <= ram_rdata_i;
      if (rd_idx_q == AddrW'(3)) b3_q   <= ram_rdata_i;
      if (rd_idx_q == AddrW'(4)) b4_q   <= ram_rdata_i;
      if (rd_idx_q == AddrW'(5)) b5_q   <= ram_rdata_i;
      if (LenW'(rd_idx_q) == len_m2) crc_lo_q <= ram_rdata_i;
      if (LenW'(rd_idx_q) == len_m1) crc_hi_q <= ram_rdata_i;
    end
    if (tag_q == TagHi) val_hi_q <= ram_rdata_i;
    if (tag_q == TagLo) val_lo_q <= ram_rdata_i;
  end

  // value count: byte count / 2, clamped to room and cap
  logic [LenW-1:0] room, half, c1, cnt;
  assign room = (len_q - MinLen) >> 1;
  assign half = LenW'(b2_q[7:1]);
  assign c1   = (half < room) ? half : room;
  assign cnt  = (c1 < LenW'(CntCap)) ? c1 : LenW'(CntCap);

  logic crc_ok, is_read, is_write;
  assign crc_ok   = (crc_q == {crc_hi_q, crc_lo_q});
  assign is_read  = crc_ok && (fc_q == FcRead);
  assign is_write = crc_ok && (fc_q == FcWrite);

  assign stat_o.frame_done = !in_action_i && (held_inc >= len_eff);
  assign stat_o.scan_last  = (LenW'(scan_q) == len_m1);
  assign stat_o.multi      = is_read && (cnt != '0);
  assign stat_o.last_val   = ((LenW'(vi_q) + LenW'(1)) == cnt);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // short write echo: bytes at or past the CRC position read as zero
  logic [7:0] w3, w4, w5;
  assign w3 = (LenW'(3) >= len_m2) ? 8'h00 : b3_q;
  assign w4 = (LenW'(4) >= len_m2) ? 8'h00 : b4_q;
  assign w5 = (LenW'(5) >= len_m2) ? 8'h00 : b5_q;

  status_e     r_status;
  logic [15:0] r_reg, r_val;
  logic [4:0]  r_idx;
  logic        r_last;
  always_comb begin
    r_status = StOk;
    r_reg    = '0;
    r_val    = '0;
    r_idx    = '0;
    r_last   = 1'b1;
    if (!crc_ok) begin
      r_status = StCrcErr;
    end else if (is_read) begin
      if (cnt == '0) begin
        r_status = StNoValues;
      end else begin
        r_val  = {val_hi_q, val_lo_q};
        r_idx  = vi_q;
        r_last = stat_o.last_val;
      end
    end else if (is_write) begin
      r_reg = {b2_q, w3};
      r_val = {w4, w5};
    end else begin
      r_status = StUnknownFc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {1'b0, r_idx, r_val, r_reg, addr_q, r_status};
      out_kind_q <= is_write;
      out_last_q <= r_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ design/modbus_rtu_response_receiver_top.sv @@
// Top level of the Modbus RTU response receiver: APB register, sequencer, datapath, frame store.
// Usage:
//  - Input stream (s_axis): one received byte per request; tuser=1 drops the partial
//    frame instead (tdata ignored). A byte request is accepted at once while the
//    block is collecting, so bytes may arrive back to back.
//  - When the byte count reaches expected_length (saturated to 5..69) the frame is
//    scanned out of the 69-byte store for CRC and header.
//  - Results (m_axis): a read reply (0x03) yields one request per register value;
//    a write echo, CRC error, unknown function or empty read gives a single request.
//    tlast marks the final one.
//  - s_axis_tready is low from the completing byte until the last result of the
//    frame is loaded into the output register; the output register then frees the
//    input side, so the next frame can start while the last result waits.
//  - A stalled m_axis holds the result and pauses the emit sequencer.
//  - Reset clears the byte count, the CRC and the output valid; expected_length
//    returns to 8. The frame store needs no clearing.
//  - APB: register 0 (byte address 0) is expected_length, bits [6:0]. Write only
//    while no frame is being processed.
`default_nettype none

module modbus_rtu_response_receiver_top
  import mrr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] action (1 = discard frame)
  // results
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,   // [1:0] status, [9:2] slave_address,
                                           // [25:10] start_register, [41:26] reg_value,
                                           // [46:42] value_index, [47] zero
  output      logic        m_axis_tuser,   // [0] function_kind
  output      logic        m_axis_tlast    // last result of the frame
);

  logic [LenW-1:0] exp_len_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegExpectedLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= RstLen;
    end else if (cfg_wr) begin
      exp_len_q <= pwdata[LenW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegExpectedLength) ? {{(32-LenW){1'b0}}, exp_len_q} : 32'h0;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  mrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrr_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .expected_length_i (exp_len_q),
    .in_action_i       (s_axis_tuser),
    .in_byte_i         (s_axis_tdata),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_data_o        (m_axis_tdata),
    .out_kind_o        (m_axis_tuser),
    .out_last_o        (m_axis_tlast)
  );

  mrr_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ sim/mrr_result_checker.sv @@
// Result checker for the Modbus RTU response receiver: tracks bytes and config, predicts and compares results.
`default_nettype none

module mrr_result_checker
  import mrr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] action
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,   // [1:0] status, [9:2] slave_address,
                                           // [25:10] start_register, [41:26] reg_value,
                                           // [46:42] value_index, [47] zero
  input  wire logic        m_axis_tuser,   // [0] function_kind
  input  wire logic        m_axis_tlast,
  output int               fail_count_o,
  output int               outstanding_o
);

  localparam logic [2:0] LenAddr = {RegExpectedLength, 2'b00};

  typedef struct packed {
    status_e     status;
    logic [7:0]  slave_addr;
    logic        write_echo;
    logic [15:0] start_reg;
    logic [15:0] reg_value;
    logic [4:0]  value_idx;
    logic        last;
  } reply_t;

  reply_t     awaited_replies[$];
  logic [7:0] rx_frame [StoreDepth];
  int         bytes_held;
  logic [6:0] len_reg;
  int         errors = 0;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic int frame_length(input logic [6:0] raw);
    if (raw < MinLen) return int'(MinLen);
    if (raw > MaxLen) return int'(MaxLen);
    return int'(raw);
  endfunction

  // write echo fields at or past the CRC slot read as zero
  function automatic logic [7:0] echo_byte(input int pos, input int n);
    return (pos >= n - 2) ? 8'h00 : rx_frame[pos];
  endfunction

  task automatic note_error(input string what, input logic [15:0] want, input logic [15:0] got);
    errors++;
    if (errors <= 10) $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  task automatic close_frame(input int n);
    logic [15:0] crc;
    logic [15:0] rx_crc;
    int          cnt;
    int          i;
    reply_t      r;
    crc = CrcInit;
    for (i = 0; i < n - 2; i++) crc = crc_next(crc, rx_frame[i]);
    rx_crc = {rx_frame[n-1], rx_frame[n-2]};
    r = '0;
    r.slave_addr = rx_frame[0];
    r.last = 1'b1;
    r.status = StOk;
    if (rx_crc != crc) begin
      r.status = StCrcErr;
      awaited_replies.push_back(r);
    end else if (rx_frame[1] == FcRead) begin
      cnt = rx_frame[2] / 2;
      if (cnt > (n - int'(MinLen)) / 2) cnt = (n - int'(MinLen)) / 2;
      if (cnt > MaxRegs) cnt = MaxRegs;
      if (cnt > ResultCap) cnt = ResultCap;
      if (cnt == 0) begin
        r.status = StNoValues;
        awaited_replies.push_back(r);
      end else begin
        for (i = 0; i < cnt; i++) begin
          r.reg_value = {rx_frame[3 + 2*i], rx_frame[4 + 2*i]};
          r.value_idx = 5'(i);
          r.last = (i == cnt - 1);
          awaited_replies.push_back(r);
        end
      end
    end else if (rx_frame[1] == FcWrite) begin
      r.write_echo = 1'b1;
      r.start_reg = {echo_byte(2, n), echo_byte(3, n)};
      r.reg_value = {echo_byte(4, n), echo_byte(5, n)};
      awaited_replies.push_back(r);
    end else begin
      r.status = StUnknownFc;
      awaited_replies.push_back(r);
    end
    bytes_held = 0;
  endtask

  task automatic take_request(input logic abort, input logic [7:0] b);
    int n;
    n = frame_length(len_reg);
    if (abort) begin
      bytes_held = 0;
    end else begin
      if (bytes_held < StoreDepth) begin
        rx_frame[bytes_held] = b;
        bytes_held++;
      end
      if (bytes_held >= n) close_frame(n);
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (awaited_replies.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: result with none awaited: %h", $time, m_axis_tdata);
      return;
    end
    want = awaited_replies.pop_front();
    if (m_axis_tdata[1:0] != want.status) note_error("status", want.status, m_axis_tdata[1:0]);
    if (m_axis_tdata[9:2] != want.slave_addr)
      note_error("slave_address", want.slave_addr, m_axis_tdata[9:2]);
    if (m_axis_tuser != want.write_echo) note_error("function_kind", want.write_echo, m_axis_tuser);
    if (m_axis_tdata[25:10] != want.start_reg)
      note_error("start_register", want.start_reg, m_axis_tdata[25:10]);
    if (m_axis_tdata[41:26] != want.reg_value)
      note_error("reg_value", want.reg_value, m_axis_tdata[41:26]);
    if (m_axis_tdata[46:42] != want.value_idx)
      note_error("value_index", want.value_idx, m_axis_tdata[46:42]);
    if (m_axis_tlast != want.last) note_error("last", want.last, m_axis_tlast);
    if (m_axis_tdata[47] != 1'b0) note_error("pad bit", 16'h0, m_axis_tdata[47]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_replies.delete();
      bytes_held = 0;
      len_reg = RstLen;
    end else begin
      if (psel && penable && pready && paddr == LenAddr) begin
        if (pwrite) begin
          len_reg = pwdata[6:0];
        end else if (prdata[6:0] != len_reg) begin
          note_error("expected_length readback", len_reg, prdata[6:0]);
        end
      end
      // results leave before a same-edge byte can add new ones
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (s_axis_tvalid && s_axis_tready) take_request(s_axis_tuser, s_axis_tdata);
    end
    outstanding_o = awaited_replies.size();
    fail_count_o = errors;
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Top of the Modbus RTU response receiver testbench: clock, reset, frame stimulus and verdict.
`default_nettype none

module testbench;
  import mrr_pkg::*;

  // byte address of expected_length on the APB port
  localparam logic [2:0] LenAddr = {RegExpectedLength, 2'b00};

  typedef enum {FrRead, FrWrite, FrUnknownFc, FrBadCrc, FrAbort, FrNoise} frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] action (1 = drop partial frame)
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [1:0] status, [9:2] slave_address, [25:10] start_register,
                               // [41:26] reg_value, [46:42] value_index, [47] zero
  logic        m_axis_tuser;   // [0] function_kind
  logic        m_axis_tlast;

  int          fail_count;
  int          outstanding;

  // idle percentages per side; the phases below change them
  int          send_idle_pct = 22;
  int          recv_idle_pct = 45;

  int          frame_len;      // effective frame length the block is set to
  int          items_sent = 0;
  logic [7:0]  frame_buf [StoreDepth];

  modbus_rtu_response_receiver_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mrr_result_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result side backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Modbus CRC-16, used to seal stimulus frames
  function automatic logic [15:0] frame_crc(input int n);
    logic [15:0] crc;
    int          i;
    int          k;
    crc = 16'hFFFF;
    for (i = 0; i < n; i++) begin
      crc = crc ^ {8'h00, frame_buf[i]};
      for (k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    return crc;
  endfunction

  // one byte or abort request; random gaps before it, then wait for acceptance
  task automatic send_item(input logic abort, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= abort;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame_bytes(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(1'b0, frame_buf[i]);
  endtask

  // CRC goes low byte first into the last two slots; corrupt flips a random nonzero mask
  task automatic seal_frame(input int n, input bit corrupt);
    logic [15:0] crc;
    crc = frame_crc(n - 2);
    if (corrupt) crc = crc ^ 16'($urandom_range(65535, 1));
    frame_buf[n-2] = crc[7:0];
    frame_buf[n-1] = crc[15:8];
  endtask

  task automatic fill_frame(input frame_kind_e kind, input int n);
    int i;
    int room;
    room = (n - int'(MinLen)) / 2;
    for (i = 0; i < n; i++) frame_buf[i] = 8'($urandom_range(255));
    case (kind)
      FrRead: begin
        frame_buf[1] = FcRead;
        // mostly a count that fits, sometimes odd, else any byte (gets clamped)
        if ($urandom_range(99) < 65)
          frame_buf[2] = 8'(2 * $urandom_range(room) + ($urandom_range(4) == 0));
      end
      FrWrite: frame_buf[1] = FcWrite;
      FrUnknownFc: begin
        do frame_buf[1] = 8'($urandom_range(255));
        while (frame_buf[1] == FcRead || frame_buf[1] == FcWrite);
      end
      FrBadCrc: begin
        case ($urandom_range(2))
          0: frame_buf[1] = FcRead;
          1: frame_buf[1] = FcWrite;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (kind != FrNoise) seal_frame(n, kind == FrBadCrc);
  endtask

  task automatic send_random_frame();
    frame_kind_e kind;
    int          r;
    int          i;
    int          held;
    r = $urandom_range(99);
    if (r < 35)      kind = FrRead;
    else if (r < 55) kind = FrWrite;
    else if (r < 65) kind = FrUnknownFc;
    else if (r < 80) kind = FrBadCrc;
    else if (r < 92) kind = FrAbort;
    else             kind = FrNoise;
    if (kind == FrAbort) begin
      held = $urandom_range(frame_len - 1);
      for (i = 0; i < held; i++) send_item(1'b0, 8'($urandom_range(255)));
      send_item(1'b1, 8'($urandom_range(255)));
    end else begin
      fill_frame(kind, frame_len);
      send_frame_bytes(frame_len);
    end
  endtask

  // sender stops until every awaited result is out
  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // APB write of expected_length followed by a readback; only when the block is quiet
  task automatic set_length(input logic [6:0] raw);
    hold_off();
    // no-result requests (aborts, partial bytes) may still be in flight
    repeat (100) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LenAddr;
    pwdata  <= {25'($urandom), raw};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (raw < MinLen)      frame_len = int'(MinLen);
    else if (raw > MaxLen) frame_len = int'(MaxLen);
    else                   frame_len = int'(raw);
  endtask

  task automatic run_segment(input logic [6:0] raw, input int budget);
    int start;
    set_length(raw);
    start = items_sent;
    while (items_sent - start < budget) begin
      // occasional full drain of the result side
      if ($urandom_range(99) < 5) hold_off();
      send_random_frame();
    end
  endtask

  // Length lowered while a frame is half in: the next byte closes the frame on
  // its first new-length bytes, which we make a well-formed reply.
  task automatic lower_mid_frame();
    int nl;
    int held;
    int i;
    if (frame_len > int'(MinLen)) begin
      nl = $urandom_range(frame_len - 1, int'(MinLen));
      held = $urandom_range(frame_len - 1, nl);
      fill_frame($urandom_range(1) ? FrRead : FrWrite, nl);
      for (i = nl; i < held; i++) frame_buf[i] = 8'($urandom_range(255));
      send_frame_bytes(held);
      set_length(7'(nl));
      send_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int drain;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    frame_len     = int'(RstLen);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed part ---
    // write echo at the reset length, every field at its top value
    foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
    frame_buf[1] = FcWrite;
    seal_frame(frame_len, 1'b0);
    send_frame_bytes(frame_len);

    // zero length saturates to the shortest frame
    set_length(7'd0);
    // read reply at address zero: no room for values, so the empty-read status
    frame_buf[0] = 8'h00;
    frame_buf[1] = FcRead;
    frame_buf[2] = 8'hFF;
    seal_frame(frame_len, 1'b0);
    send_frame_bytes(frame_len);
    // short write echo: only the register high byte is inside the frame
    fill_frame(FrWrite, frame_len);
    send_frame_bytes(frame_len);
    // unknown function code
    frame_buf[0] = 8'h5A;
    frame_buf[1] = 8'hFF;
    frame_buf[2] = 8'h00;
    seal_frame(frame_len, 1'b0);
    send_frame_bytes(frame_len);
    // CRC error
    fill_frame(FrBadCrc, frame_len);
    send_frame_bytes(frame_len);
    // partial frame dropped
    send_item(1'b0, 8'h11);
    send_item(1'b0, FcRead);
    send_item(1'b1, 8'hFF);

    // --- random part, sender 22 / receiver 45 ---
    run_segment(7'($urandom_range(12, 6)), 90);
    lower_mid_frame();
    // over-range length saturates to the full store; longest read reply
    set_length(7'd127);
    fill_frame(FrRead, frame_len);
    frame_buf[2] = 8'd64;
    seal_frame(frame_len, 1'b0);
    send_frame_bytes(frame_len);

    // --- sender 45 / receiver 22 ---
    send_idle_pct = 45;
    recv_idle_pct = 22;
    run_segment(7'($urandom_range(30, 13)), 70);
    lower_mid_frame();
    run_segment(MaxLen, 69);

    // --- no idling ---
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(7'($urandom_range(10, 1)), 80);
    lower_mid_frame();

    // drain, then let the block settle before the verdict
    s_axis_tvalid <= 1'b0;
    for (drain = 0; outstanding != 0 && drain < 50000; drain++) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("modbus_rtu_response_receiver_top: match");
    end else begin
      $display("modbus_rtu_response_receiver_top: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("modbus_rtu_response_receiver_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/mrr_pkg.sv
design/mrr_ram.sv
design/mrr_ctrl.sv
design/mrr_datapath.sv
design/modbus_rtu_response_receiver_top.sv
sim/mrr_result_checker.sv
sim/testbench.sv
